// ===== hw/rtl/round_robin_vc_allocator_defines.svh =====
// assertion macros shared by the allocator rtl
`ifndef ROUND_ROBIN_VC_ALLOCATOR_DEFINES_SVH
`define ROUND_ROBIN_VC_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define RRVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define RRVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RRVA_ASSERT(lbl, prop, msg)
`define RRVA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/rrva_pkg.sv =====
package rrva_pkg;

  localparam int ActW      = 2;
  localparam int PortW     = 3;
  localparam int VnW       = 1;
  localparam int VcW       = 2;
  localparam int DestW     = 3;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 8;
  localparam int PortsCfgW = 4;
  localparam int VnsCfgW   = 2;
  localparam int VcsCfgW   = 3;
  localparam int MaskW     = 8;

  localparam int MaxResults = 8;
  localparam int ResCntW    = 4;

  typedef enum logic [ActW-1:0] {
    ACT_REQUEST = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_ROUND   = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PORTS    = 3'd0,
    CFG_VNS      = 3'd1,
    CFG_VCS      = 3'd2,
    CFG_PRESENT  = 3'd3,
    CFG_ENDPOINT = 3'd4,
    CFG_WRAP     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic             grant_valid;
    logic [PortW-1:0] granted_port;
    logic [VnW-1:0]   granted_vn;
    logic [VcW-1:0]   granted_src_vc;
    logic [DestW-1:0] granted_out_port;
    logic [VcW-1:0]   granted_out_vc;
    logic             route_error;
    logic             last_of_round;
  } res_t;

endpackage

// ===== hw/rtl/rrva_src_scan.sv =====
module rrva_src_scan #(
  parameter int MaxVns = 2,
  parameter int MaxVcs = 4
) (
  input  logic [MaxVns*MaxVcs-1:0]                       pend_i,
  input  logic [$clog2(MaxVns+1)-1:0]                    nv_i,
  input  logic [$clog2(MaxVcs+1)-1:0]                    nc_i,
  input  logic [((MaxVns > 1) ? $clog2(MaxVns) : 1)-1:0] vn_ptr_i,
  input  logic [((MaxVcs > 1) ? $clog2(MaxVcs) : 1)-1:0] vc_ptr_i,
  output logic                                           found_o,
  output logic [((MaxVns > 1) ? $clog2(MaxVns) : 1)-1:0] vn_o,
  output logic [((MaxVcs > 1) ? $clog2(MaxVcs) : 1)-1:0] vc_o
);

  localparam int VNW = (MaxVns > 1) ? $clog2(MaxVns) : 1;
  localparam int VCW = (MaxVcs > 1) ? $clog2(MaxVcs) : 1;

  // rotating scan: vns from vn_ptr, inside each vn vcs from vc_ptr
  always_comb begin
    found_o = 1'b0;
    vn_o    = '0;
    vc_o    = '0;
    for (int a = MaxVns - 1; a >= 0; a--) begin
      for (int b = MaxVcs - 1; b >= 0; b--) begin
        int v;
        int c;
        v = int'(vn_ptr_i) + a;
        if (v >= int'(nv_i)) v = v - int'(nv_i);
        c = int'(vc_ptr_i) + b;
        if (c >= int'(nc_i)) c = c - int'(nc_i);
        if ((a < int'(nv_i)) && (b < int'(nc_i)) && pend_i[v*MaxVcs + c]) begin
          found_o = 1'b1;
          vn_o    = VNW'(v);
          vc_o    = VCW'(c);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/round_robin_vc_allocator.sv =====
// round-robin virtual-channel allocator
// input channel (in_valid_i/in_ready_o) takes one transaction per action:
//   request posts a head flit of an input vc with its routed output port,
//   release frees an output vc, round runs one allocation pass
// requests and releases give no result
// a round first reduces the pointers to the counts in use (one subtract per
// cycle while a pointer is out of range), then visits the ports in turn
// through one shared scan and pick unit: a port with nothing pending is left
// from the scan state, a port with a pending head flit goes on to a decide
// state (the routed port comes from a memory with registered read), and the
// decide state holds while an output stall blocks the next result
// each round gives 1 to 8 results on the output channel, the last one
// flagged with last_of_round; an empty round gives one result, zero but
// for that flag; in_ready_o is high only between rounds
// a result waits in an output register while the receiver stalls; the round
// holds before pushing the next result until that register is free
// reset clears all pending requests, marks all output vcs idle, zeroes the
// pointers and loads the register defaults (8 ports, 2 vns, 4 vcs, all
// ports present, no endpoint or wrap-around ports)
`include "round_robin_vc_allocator_defines.svh"

module round_robin_vc_allocator #(
  parameter int MaxPorts = 8,
  parameter int MaxVns   = 2,
  parameter int MaxVcs   = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rrva_pkg::ActW-1:0]     action_i,
  input  logic [rrva_pkg::PortW-1:0]    port_i,
  input  logic [rrva_pkg::VnW-1:0]      vnet_i,
  input  logic [rrva_pkg::VcW-1:0]      chan_i,
  input  logic [rrva_pkg::DestW-1:0]    dest_port_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          grant_valid_o,
  output logic [rrva_pkg::PortW-1:0]    granted_port_o,
  output logic [rrva_pkg::VnW-1:0]      granted_vn_o,
  output logic [rrva_pkg::VcW-1:0]      granted_src_vc_o,
  output logic [rrva_pkg::DestW-1:0]    granted_out_port_o,
  output logic [rrva_pkg::VcW-1:0]      granted_out_vc_o,
  output logic                          route_error_o,
  output logic                          last_of_round_o,
  input  logic                          cfg_we_i,
  input  logic [rrva_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rrva_pkg::CfgDataW-1:0] cfg_data_i
);
  import rrva_pkg::*;

  localparam int PW      = $clog2(MaxPorts);
  localparam int VNW     = (MaxVns > 1) ? $clog2(MaxVns) : 1;
  localparam int VCW     = (MaxVcs > 1) ? $clog2(MaxVcs) : 1;
  localparam int NPW     = $clog2(MaxPorts + 1);
  localparam int NVW     = $clog2(MaxVns + 1);
  localparam int NCW     = $clog2(MaxVcs + 1);
  localparam int RowW    = MaxVns * MaxVcs;
  localparam int Entries = MaxPorts * RowW;
  localparam int EW      = $clog2(Entries);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_NORM   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  function automatic logic [EW-1:0] slot_f(input int p, input int v, input int c);
    return EW'((p * MaxVns + v) * MaxVcs + c);
  endfunction

  function automatic logic port_bit_f(input logic [MaskW-1:0] mask, input int p);
    return (p < MaskW) && mask[3'(p)];
  endfunction

  // configuration
  logic [PortsCfgW-1:0] ports_q;
  logic [VnsCfgW-1:0]   vns_q;
  logic [VcsCfgW-1:0]   vcs_q;
  logic [MaskW-1:0]     present_q, endpoint_q, wrap_q;

  // control
  logic [2:0]         state_q, state_d;
  logic [PW-1:0]      pptr_q, pptr_d;
  logic [VNW-1:0]     vptr_q, vptr_d;
  logic [VCW-1:0]     sptr_q, sptr_d;
  logic [VCW-1:0]     dptr_q, dptr_d;
  logic [PW-1:0]      cur_q, cur_d;
  logic [PW-1:0]      idx_q, idx_d;
  logic [ResCntW-1:0] rcnt_q, rcnt_d;
  logic               held_valid_q, held_valid_d;
  logic               out_valid_q, out_valid_d;

  // payload
  logic [VNW-1:0]   svn_q, svn_d;
  logic [VCW-1:0]   svc_q, svc_d;
  res_t             held_q, held_d;
  res_t             out_q, out_d;
  logic [DestW-1:0] rd_q;
  logic [DestW-1:0] dest_mem [Entries];

  logic [Entries-1:0] pend_q;
  logic [Entries-1:0] busy_q;

  logic [NPW-1:0] np;
  logic [NVW-1:0] nv;
  logic [NCW-1:0] nc;

  assign np = (ports_q == '0) ? NPW'(1) :
              ((int'(ports_q) > MaxPorts) ? NPW'(MaxPorts) : NPW'(ports_q));
  assign nv = (vns_q == '0) ? NVW'(1) :
              ((int'(vns_q) > MaxVns) ? NVW'(MaxVns) : NVW'(vns_q));
  assign nc = (vcs_q == '0) ? NCW'(1) :
              ((int'(vcs_q) > MaxVcs) ? NCW'(MaxVcs) : NCW'(vcs_q));

  // input side
  logic    in_acc;
  logic    in_inside;
  logic    req_we, rel_we;
  logic [EW-1:0] in_slot;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_inside  = (int'(port_i) < MaxPorts) && (int'(vnet_i) < MaxVns) &&
                      (int'(chan_i) < MaxVcs);
  assign in_slot    = slot_f(int'(port_i), int'(vnet_i), int'(chan_i));
  assign req_we     = in_acc && (action_i == ACT_REQUEST) && in_inside;
  assign rel_we     = in_acc && (action_i == ACT_RELEASE) && in_inside;

  // source scan of the visited port
  logic [RowW-1:0] pend_row;
  logic            scan_found;
  logic [VNW-1:0]  scan_vn;
  logic [VCW-1:0]  scan_vc;
  logic            cur_present;
  logic [EW-1:0]   rd_addr;

  always_comb begin
    for (int k = 0; k < RowW; k++) begin
      pend_row[k] = pend_q[EW'(int'(cur_q) * RowW + k)];
    end
  end

  rrva_src_scan #(
    .MaxVns(MaxVns),
    .MaxVcs(MaxVcs)
  ) u_src_scan (
    .pend_i  (pend_row),
    .nv_i    (nv),
    .nc_i    (nc),
    .vn_ptr_i(vptr_q),
    .vc_ptr_i(sptr_q),
    .found_o (scan_found),
    .vn_o    (scan_vn),
    .vc_o    (scan_vc)
  );

  assign cur_present = port_bit_f(present_q, int'(cur_q));
  assign rd_addr     = slot_f(int'(cur_q), int'(scan_vn), int'(scan_vc));

  // output vc pick for the routed port
  logic            dp_bad;
  logic [PW-1:0]   dpi;
  logic [MaxVcs-1:0] brow;
  logic            rr_found;
  logic [VCW-1:0]  rr_vc;
  logic            gfound;
  logic [VCW-1:0]  govc;
  logic [VCW-1:0]  top_vc;
  logic [EW-1:0]   gidx;
  logic [EW-1:0]   src_idx;

  assign dp_bad = (int'(rd_q) >= int'(np)) || !port_bit_f(present_q, int'(rd_q));
  assign dpi    = dp_bad ? '0 : PW'(rd_q);
  assign top_vc = VCW'(int'(nc) - 1);

  always_comb begin
    for (int c = 0; c < MaxVcs; c++) begin
      brow[c] = busy_q[slot_f(int'(dpi), int'(svn_q), c)];
    end
  end

  always_comb begin
    rr_found = 1'b0;
    rr_vc    = '0;
    for (int b = MaxVcs - 1; b >= 0; b--) begin
      int c;
      c = int'(dptr_q) + b;
      if (c >= int'(nc)) c = c - int'(nc);
      if ((b < int'(nc)) && (c >= int'(svc_q)) && !brow[c]) begin
        rr_found = 1'b1;
        rr_vc    = VCW'(c);
      end
    end
  end

  always_comb begin
    priority if (endpoint_q[rd_q]) begin
      gfound = !brow[0];
      govc   = '0;
    end else if ((int'(nc) > 1) && wrap_q[rd_q]) begin
      gfound = !brow[top_vc];
      govc   = top_vc;
    end else begin
      gfound = rr_found;
      govc   = rr_vc;
    end
  end

  assign gidx    = slot_f(int'(dpi), int'(svn_q), int'(govc));
  assign src_idx = slot_f(int'(cur_q), int'(svn_q), int'(svc_q));

  // result of the decide step
  logic emit;
  logic log_res;
  logic out_free;
  logic stall;
  logic grant_now;
  logic clr_pend;
  logic adv;
  logic last_port;
  logic ptr_norm;
  res_t res;

  assign emit      = dp_bad || gfound;
  assign log_res   = emit && (int'(rcnt_q) < MaxResults);
  assign out_free  = !out_valid_q || out_ready_i;
  assign stall     = log_res && held_valid_q && !out_free;
  assign clr_pend  = (state_q == S_DECIDE) && !stall && emit;
  assign grant_now = clr_pend && !dp_bad;
  assign adv       = ((state_q == S_SCAN) && !(cur_present && scan_found)) ||
                     ((state_q == S_DECIDE) && !stall);
  assign last_port = (int'(idx_q) == int'(np) - 1);
  assign ptr_norm  = (int'(pptr_q) < int'(np)) && (int'(vptr_q) < int'(nv)) &&
                     (int'(sptr_q) < int'(nc)) && (int'(dptr_q) < int'(nc));

  always_comb begin
    res.grant_valid      = !dp_bad;
    res.granted_port     = PortW'(cur_q);
    res.granted_vn       = VnW'(svn_q);
    res.granted_src_vc   = VcW'(svc_q);
    res.granted_out_port = rd_q;
    res.granted_out_vc   = dp_bad ? '0 : VcW'(govc);
    res.route_error      = dp_bad;
    res.last_of_round    = 1'b0;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    pptr_d       = pptr_q;
    vptr_d       = vptr_q;
    sptr_d       = sptr_q;
    dptr_d       = dptr_q;
    cur_d        = cur_q;
    idx_d        = idx_q;
    rcnt_d       = rcnt_q;
    held_valid_d = held_valid_q;
    held_d       = held_q;
    svn_d        = svn_q;
    svc_d        = svc_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (action_i == ACT_ROUND)) begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (ptr_norm) begin
          cur_d   = pptr_q;
          idx_d   = '0;
          rcnt_d  = '0;
          state_d = S_SCAN;
        end else begin
          if (int'(pptr_q) >= int'(np)) pptr_d = pptr_q - PW'(np);
          if (int'(vptr_q) >= int'(nv)) vptr_d = vptr_q - VNW'(nv);
          if (int'(sptr_q) >= int'(nc)) sptr_d = sptr_q - VCW'(nc);
          if (int'(dptr_q) >= int'(nc)) dptr_d = dptr_q - VCW'(nc);
        end
      end
      S_SCAN: begin
        if (cur_present && scan_found) begin
          svn_d   = scan_vn;
          svc_d   = scan_vc;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (log_res && !stall) begin
          if (held_valid_q) begin
            out_d       = held_q;
            out_valid_d = 1'b1;
          end
          held_d       = res;
          held_valid_d = 1'b1;
          rcnt_d       = rcnt_q + 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_d               = held_valid_q ? held_q : '0;
          out_d.last_of_round = 1'b1;
          out_valid_d         = 1'b1;
          held_valid_d        = 1'b0;
          pptr_d  = (int'(pptr_q) + 1 == int'(np)) ? '0 : pptr_q + 1'b1;
          vptr_d  = (int'(vptr_q) + 1 == int'(nv)) ? '0 : vptr_q + 1'b1;
          sptr_d  = (int'(sptr_q) + 1 == int'(nc)) ? '0 : sptr_q + 1'b1;
          dptr_d  = (int'(dptr_q) + 1 == int'(nc)) ? '0 : dptr_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (adv) begin
      if (last_port) begin
        state_d = S_FINISH;
      end else begin
        idx_d   = idx_q + 1'b1;
        cur_d   = (int'(cur_q) + 1 == int'(np)) ? '0 : cur_q + 1'b1;
        state_d = S_SCAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ports_q      <= PortsCfgW'(8);
      vns_q        <= VnsCfgW'(2);
      vcs_q        <= VcsCfgW'(4);
      present_q    <= '1;
      endpoint_q   <= '0;
      wrap_q       <= '0;
      state_q      <= S_IDLE;
      pptr_q       <= '0;
      vptr_q       <= '0;
      sptr_q       <= '0;
      dptr_q       <= '0;
      cur_q        <= '0;
      idx_q        <= '0;
      rcnt_q       <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_q       <= '0;
      busy_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_PORTS:    ports_q    <= cfg_data_i[PortsCfgW-1:0];
          CFG_VNS:      vns_q      <= cfg_data_i[VnsCfgW-1:0];
          CFG_VCS:      vcs_q      <= cfg_data_i[VcsCfgW-1:0];
          CFG_PRESENT:  present_q  <= cfg_data_i[MaskW-1:0];
          CFG_ENDPOINT: endpoint_q <= cfg_data_i[MaskW-1:0];
          CFG_WRAP:     wrap_q     <= cfg_data_i[MaskW-1:0];
          default: ;
        endcase
      end
      state_q      <= state_d;
      pptr_q       <= pptr_d;
      vptr_q       <= vptr_d;
      sptr_q       <= sptr_d;
      dptr_q       <= dptr_d;
      cur_q        <= cur_d;
      idx_q        <= idx_d;
      rcnt_q       <= rcnt_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
      if (req_we) pend_q[in_slot] <= 1'b1;
      if (clr_pend) pend_q[src_idx] <= 1'b0;
      if (rel_we) busy_q[in_slot] <= 1'b0;
      if (grant_now) busy_q[gidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    svn_q  <= svn_d;
    svc_q  <= svc_d;
    held_q <= held_d;
    out_q  <= out_d;
    if (req_we) dest_mem[in_slot] <= dest_port_i;
    if ((state_q == S_SCAN) && cur_present && scan_found) rd_q <= dest_mem[rd_addr];
  end

  assign out_valid_o        = out_valid_q;
  assign grant_valid_o      = out_q.grant_valid;
  assign granted_port_o     = out_q.granted_port;
  assign granted_vn_o       = out_q.granted_vn;
  assign granted_src_vc_o   = out_q.granted_src_vc;
  assign granted_out_port_o = out_q.granted_out_port;
  assign granted_out_vc_o   = out_q.granted_out_vc;
  assign route_error_o      = out_q.route_error;
  assign last_of_round_o    = out_q.last_of_round;

  `RRVA_ASSERT_ALWAYS(a_no_held_in_idle, (held_valid_q |-> (state_q != S_IDLE)), "held result left at idle")
  `RRVA_ASSERT(a_finish_last, ((state_q == S_FINISH) && out_free) |=> (out_valid_q && out_q.last_of_round), "round end without last result")
  `RRVA_ASSERT(a_scan_range, (state_q == S_SCAN) |-> ((int'(cur_q) < int'(np)) && (int'(idx_q) < int'(np))), "port visit out of range")

endmodule

// ===== dv/round_robin_vc_allocator_tb.sv =====
`timescale 1ns / 1ps

module round_robin_vc_allocator_tb;
  import rrva_pkg::*;

  localparam int NumPorts = 8;
  localparam int NumVns = 2;
  localparam int NumVcs = 4;
  localparam int NumSlots = NumPorts * NumVns * NumVcs;
  localparam int SettleCycles = 32;
  localparam int StallLimit = 2000;
  localparam int NumRows = 27;
  localparam logic [ActW-1:0] ACT_UNUSED = 2'd3;
  localparam res_t EMPTY_ROUND = '{1'b0, 3'd0, 1'b0, 2'd0, 3'd0, 2'd0, 1'b0, 1'b1};

  typedef struct packed {
    logic [PortsCfgW-1:0] ports;
    logic [VnsCfgW-1:0]   vns;
    logic [VcsCfgW-1:0]   vcs;
    logic [MaskW-1:0]     present;
    logic [MaskW-1:0]     endpoint;
    logic [MaskW-1:0]     wrap;
  } cfg_word_t;

  typedef struct packed {
    bit               reconfig;
    cfg_word_t        regs;
    logic [ActW-1:0]  act;
    logic [PortW-1:0] port;
    logic [VnW-1:0]   vn;
    logic [VcW-1:0]   chan;
    logic [DestW-1:0] dest;
    bit               typed;
    res_t             res;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [ActW-1:0]     action_i = '0;
  logic [PortW-1:0]    port_i = '0;
  logic [VnW-1:0]      vnet_i = '0;
  logic [VcW-1:0]      chan_i = '0;
  logic [DestW-1:0]    dest_port_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                grant_valid_o;
  logic [PortW-1:0]    granted_port_o;
  logic [VnW-1:0]      granted_vn_o;
  logic [VcW-1:0]      granted_src_vc_o;
  logic [DestW-1:0]    granted_out_port_o;
  logic [VcW-1:0]      granted_out_vc_o;
  logic                route_error_o;
  logic                last_of_round_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  round_robin_vc_allocator u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // allocator state as the testbench sees it
  logic [PortsCfgW-1:0] cfg_ports = 4'd8;
  logic [VnsCfgW-1:0]   cfg_vns = 2'd2;
  logic [VcsCfgW-1:0]   cfg_vcs = 3'd4;
  logic [MaskW-1:0]     cfg_present = 8'hff;
  logic [MaskW-1:0]     cfg_endpoint = 8'h00;
  logic [MaskW-1:0]     cfg_wrap = 8'h00;
  bit                   pend_valid [NumSlots];
  logic [DestW-1:0]     pend_dest [NumSlots];
  bit                   vc_busy [NumSlots];
  int                   port_ptr = 0;
  int                   vn_ptr = 0;
  int                   svc_ptr = 0;
  int                   dvc_ptr = 0;

  res_t predicted[$];
  res_t expected_grants[$];
  row_t dir_rows [NumRows];
  bit   gaps_on = 1'b1;
  int   mismatches = 0;
  int   items_sent = 0;
  int   results_checked = 0;
  int   reg_writes = 0;
  int   quiet_cycles = 0;

  initial begin
    foreach (pend_valid[i]) begin
      pend_valid[i] = 1'b0;
      vc_busy[i] = 1'b0;
    end
  end

  function automatic int slot(int p, int v, int c);
    return (p * NumVns + v) * NumVcs + c;
  endfunction

  function automatic int eff_count(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic bit port_on(logic [MaskW-1:0] mask, int p);
    return p < 8 && mask[p];
  endfunction

  function automatic int pick_out_vc(int op, int vn, int svc, int nc);
    int c;
    if (port_on(cfg_endpoint, op)) return vc_busy[slot(op, vn, 0)] ? -1 : 0;
    if (nc > 1 && port_on(cfg_wrap, op)) return vc_busy[slot(op, vn, nc - 1)] ? -1 : nc - 1;
    c = dvc_ptr % nc;
    for (int i = 0; i < nc; i++) begin
      if (c >= svc && !vc_busy[slot(op, vn, c)]) return c;
      c = (c + 1) % nc;
    end
    return -1;
  endfunction

  // fills predicted with the results of one transaction
  function automatic void apply_action(logic [ActW-1:0] act, int p, int vn, int c, int dp);
    int np, nv, nc, pp, v, cc, svn, svc, op, ovc;
    bit found;
    res_t r;
    predicted.delete();
    case (act)
      ACT_REQUEST: begin
        pend_valid[slot(p, vn, c)] = 1'b1;
        pend_dest[slot(p, vn, c)] = DestW'(dp);
      end
      ACT_RELEASE: vc_busy[slot(p, vn, c)] = 1'b0;
      ACT_ROUND: begin
        np = eff_count(cfg_ports, NumPorts);
        nv = eff_count(cfg_vns, NumVns);
        nc = eff_count(cfg_vcs, NumVcs);
        pp = port_ptr % np;
        for (int i = 0; i < np; i++) begin
          found = 1'b0;
          svn = 0;
          svc = 0;
          if (port_on(cfg_present, pp)) begin
            v = vn_ptr % nv;
            for (int a = 0; a < nv; a++) begin
              cc = svc_ptr % nc;
              for (int b = 0; b < nc; b++) begin
                if (!found && pend_valid[slot(pp, v, cc)]) begin
                  found = 1'b1;
                  svn = v;
                  svc = cc;
                end
                cc = (cc + 1) % nc;
              end
              v = (v + 1) % nv;
            end
          end
          if (found) begin
            op = pend_dest[slot(pp, svn, svc)];
            r = '0;
            r.granted_port = PortW'(pp);
            r.granted_vn = VnW'(svn);
            r.granted_src_vc = VcW'(svc);
            r.granted_out_port = DestW'(op);
            if (op >= np || !port_on(cfg_present, op)) begin
              pend_valid[slot(pp, svn, svc)] = 1'b0;
              r.route_error = 1'b1;
              predicted.push_back(r);
            end else begin
              ovc = pick_out_vc(op, svn, svc, nc);
              if (ovc >= 0) begin
                vc_busy[slot(op, svn, ovc)] = 1'b1;
                pend_valid[slot(pp, svn, svc)] = 1'b0;
                r.grant_valid = 1'b1;
                r.granted_out_vc = VcW'(ovc);
                predicted.push_back(r);
              end
            end
          end
          pp = (pp + 1) % np;
        end
        if (predicted.size() == 0) predicted.push_back('0);
        predicted[predicted.size() - 1].last_of_round = 1'b1;
        port_ptr = (port_ptr % np + 1) % np;
        vn_ptr = (vn_ptr % nv + 1) % nv;
        svc_ptr = (svc_ptr % nc + 1) % nc;
        dvc_ptr = (dvc_ptr % nc + 1) % nc;
      end
      default: ;
    endcase
  endfunction

  function automatic void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] d);
    case (idx)
      CFG_PORTS:    cfg_ports = d[PortsCfgW-1:0];
      CFG_VNS:      cfg_vns = d[VnsCfgW-1:0];
      CFG_VCS:      cfg_vcs = d[VcsCfgW-1:0];
      CFG_PRESENT:  cfg_present = d;
      CFG_ENDPOINT: cfg_endpoint = d;
      CFG_WRAP:     cfg_wrap = d;
      default: ;
    endcase
  endfunction

  function automatic row_t item_row(logic [ActW-1:0] act, logic [PortW-1:0] p,
                                    logic [VnW-1:0] vn, logic [VcW-1:0] c,
                                    logic [DestW-1:0] dp);
    row_t r;
    r = '0;
    r.act = act;
    r.port = p;
    r.vn = vn;
    r.chan = c;
    r.dest = dp;
    return r;
  endfunction

  function automatic row_t typed_round(res_t want);
    row_t r;
    r = '0;
    r.act = ACT_ROUND;
    r.typed = 1'b1;
    r.res = want;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [PortsCfgW-1:0] ports, logic [VnsCfgW-1:0] vns,
                                   logic [VcsCfgW-1:0] vcs, logic [MaskW-1:0] pres,
                                   logic [MaskW-1:0] ep, logic [MaskW-1:0] wr);
    row_t r;
    r = '0;
    r.reconfig = 1'b1;
    r.regs = '{ports, vns, vcs, pres, ep, wr};
    return r;
  endfunction

  function automatic void check_field(string fld, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
    end
  endfunction

  task automatic send_item(logic [ActW-1:0] act, logic [PortW-1:0] p, logic [VnW-1:0] vn,
                           logic [VcW-1:0] c, logic [DestW-1:0] dp, bit typed, res_t want);
    if (gaps_on && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 27);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    port_i <= p;
    vnet_i <= vn;
    chan_i <= c;
    dest_port_i <= dp;
    do @(posedge clk_i); while (!in_ready_o);
    apply_action(act, p, vn, c, dp);
    if (typed) expected_grants.push_back(want);
    else foreach (predicted[i]) expected_grants.push_back(predicted[i]);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    set_reg(idx, d);
    reg_writes++;
  endtask

  task automatic load_config(cfg_word_t w);
    drain_results();
    write_reg(CFG_PORTS, CfgDataW'(w.ports));
    write_reg(CFG_VNS, CfgDataW'(w.vns));
    write_reg(CFG_VCS, CfgDataW'(w.vcs));
    write_reg(CFG_PRESENT, w.present);
    write_reg(CFG_ENDPOINT, w.endpoint);
    write_reg(CFG_WRAP, w.wrap);
    cfg_we_i <= 1'b0;
  endtask

  // mostly well-formed traffic inside the counts in use, some out of range
  task automatic run_random(int n, bit pause_midway);
    int np, nv, nc, done, roll, tp, tv, tc;
    logic [ActW-1:0] act;
    logic [PortW-1:0] p;
    logic [VnW-1:0] vn;
    logic [VcW-1:0] c;
    logic [DestW-1:0] dp;
    bit hit;
    done = 0;
    while (done < n) begin
      np = eff_count(cfg_ports, NumPorts);
      nv = eff_count(cfg_vns, NumVns);
      nc = eff_count(cfg_vcs, NumVcs);
      roll = $urandom_range(99);
      if (roll < 45) act = ACT_REQUEST;
      else if (roll < 67) act = ACT_RELEASE;
      else if (roll < 95) act = ACT_ROUND;
      else act = ACT_UNUSED;
      p = PortW'(($urandom_range(9) < 8) ? $urandom_range(np - 1) : $urandom_range(7));
      vn = VnW'(($urandom_range(9) < 8) ? $urandom_range(nv - 1) : $urandom_range(1));
      c = VcW'(($urandom_range(9) < 8) ? $urandom_range(nc - 1) : $urandom_range(3));
      dp = DestW'(($urandom_range(9) < 8) ? $urandom_range(np - 1) : $urandom_range(7));
      if (act == ACT_RELEASE && $urandom_range(3) != 0) begin
        hit = 1'b0;
        for (int t = 0; t < 8; t++) begin
          tp = $urandom_range(np - 1);
          tv = $urandom_range(nv - 1);
          tc = $urandom_range(nc - 1);
          if (!hit && vc_busy[slot(tp, tv, tc)]) begin
            hit = 1'b1;
            p = PortW'(tp);
            vn = VnW'(tv);
            c = VcW'(tc);
          end
        end
      end
      send_item(act, p, vn, c, dp, 1'b0, EMPTY_ROUND);
      if (act != ACT_UNUSED) begin
        done++;
        if (pause_midway && done == n / 2) drain_results();
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= !gaps_on || ($urandom_range(99) >= 27);
  end

  always @(posedge clk_i) begin : result_check
    res_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {grant_valid_o, granted_port_o, granted_vn_o, granted_src_vc_o,
             granted_out_port_o, granted_out_vc_o, route_error_o, last_of_round_o};
      if (expected_grants.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = expected_grants.pop_front();
        check_field("grant_valid", want.grant_valid, got.grant_valid);
        check_field("granted_port", want.granted_port, got.granted_port);
        check_field("granted_vn", want.granted_vn, got.granted_vn);
        check_field("granted_src_vc", want.granted_src_vc, got.granted_src_vc);
        check_field("granted_out_port", want.granted_out_port, got.granted_out_port);
        check_field("granted_out_vc", want.granted_out_vc, got.granted_out_vc);
        check_field("route_error", want.route_error, got.route_error);
        check_field("last_of_round", want.last_of_round, got.last_of_round);
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    cfg_word_t w;
    dir_rows = '{
      typed_round(EMPTY_ROUND),
      item_row(ACT_REQUEST, 3'd0, 1'd0, 2'd0, 3'd7),
      item_row(ACT_REQUEST, 3'd7, 1'd1, 2'd3, 3'd0),
      item_row(ACT_UNUSED, 3'd7, 1'd1, 2'd3, 3'd7),
      item_row(ACT_ROUND, 3'd0, 1'd0, 2'd0, 3'd0),
      item_row(ACT_RELEASE, 3'd7, 1'd0, 2'd1, 3'd0),
      item_row(ACT_RELEASE, 3'd0, 1'd1, 2'd3, 3'd0),
      // port 4 absent, port 1 endpoint, port 2 wrap-around
      cfg_row(4'd5, 2'd2, 3'd4, 8'hef, 8'h02, 8'h04),
      item_row(ACT_REQUEST, 3'd0, 1'd0, 2'd0, 3'd6),
      typed_round('{1'b0, 3'd0, 1'b0, 2'd0, 3'd6, 2'd0, 1'b1, 1'b1}),
      item_row(ACT_REQUEST, 3'd3, 1'd1, 2'd2, 3'd4),
      typed_round('{1'b0, 3'd3, 1'b1, 2'd2, 3'd4, 2'd0, 1'b1, 1'b1}),
      item_row(ACT_REQUEST, 3'd2, 1'd1, 2'd3, 3'd1),
      item_row(ACT_REQUEST, 3'd3, 1'd0, 2'd1, 3'd2),
      item_row(ACT_ROUND, 3'd0, 1'd0, 2'd0, 3'd0),
      // endpoint vc already taken, request stalls until released
      item_row(ACT_REQUEST, 3'd0, 1'd1, 2'd1, 3'd1),
      item_row(ACT_ROUND, 3'd0, 1'd0, 2'd0, 3'd0),
      item_row(ACT_RELEASE, 3'd1, 1'd1, 2'd0, 3'd0),
      item_row(ACT_ROUND, 3'd0, 1'd0, 2'd0, 3'd0),
      item_row(ACT_REQUEST, 3'd6, 1'd0, 2'd0, 3'd0),
      cfg_row(4'd0, 2'd0, 3'd0, 8'h00, 8'h00, 8'hff),
      item_row(ACT_REQUEST, 3'd0, 1'd0, 2'd0, 3'd0),
      typed_round(EMPTY_ROUND),
      cfg_row(4'd15, 2'd3, 3'd7, 8'hff, 8'h00, 8'h00),
      item_row(ACT_ROUND, 3'd0, 1'd0, 2'd0, 3'd0),
      item_row(ACT_REQUEST, 3'd5, 1'd1, 2'd3, 3'd5),
      item_row(ACT_ROUND, 3'd0, 1'd0, 2'd0, 3'd0)
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].reconfig) begin
        load_config(dir_rows[i].regs);
      end else begin
        send_item(dir_rows[i].act, dir_rows[i].port, dir_rows[i].vn, dir_rows[i].chan,
                  dir_rows[i].dest, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      w.ports = PortsCfgW'($urandom_range(15));
      w.vns = VnsCfgW'($urandom_range(3));
      w.vcs = VcsCfgW'($urandom_range(7));
      w.present = MaskW'($urandom_range(255) | $urandom_range(255));
      w.endpoint = MaskW'($urandom_range(255) & $urandom_range(255));
      w.wrap = MaskW'($urandom_range(255) & $urandom_range(255));
      gaps_on = 1'b1;
      case (ph)
        1: begin
          w.ports = 4'd15;
          w.vns = 2'd3;
          w.vcs = 3'd7;
          w.present = 8'hff;
          gaps_on = 1'b0;
        end
        3: begin
          w.ports = PortsCfgW'($urandom_range(3));
          w.vns = VnsCfgW'($urandom_range(1));
          w.vcs = VcsCfgW'($urandom_range(2));
        end
        default: ;
      endcase
      load_config(w);
      run_random(38, ph == 2);
    end

    in_valid_i <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered requests, releases and rounds over %0d register writes,", reg_writes);
    $display("%0d transactions in, %0d results checked", items_sent, results_checked);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
